>>> hw/rtl/rau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rau_pkg: rational arithmetic unit shared definitions
// Widths, command codes and state encodings used by the unit and its parts.
// -----------------------------------------------------------------------------
package rau_pkg;

  localparam int unsigned OperandWidth = 16;
  localparam int unsigned ProdWidth    = 2 * OperandWidth;
  localparam int unsigned MagWidth     = ProdWidth + 1;
  localparam int unsigned ResWidth     = 33;
  localparam int unsigned ExtWidth     = (MagWidth > ResWidth) ? MagWidth : ResWidth;
  localparam int unsigned MulCntWidth  = $clog2(OperandWidth + 1);
  localparam int unsigned DivCntWidth  = $clog2(MagWidth + 1);
  localparam int unsigned InDataWidth  = ((4 * OperandWidth + 7) / 8) * 8;
  localparam int unsigned OutDataWidth = ((2 * ResWidth + 7) / 8) * 8;
  localparam int unsigned CmdWidth     = 2;

  typedef logic [MagWidth-1:0] mag_t;

  typedef enum logic [CmdWidth-1:0] {
    CmdAdd = 2'd0,
    CmdSub = 2'd1,
    CmdMul = 2'd2,
    CmdDiv = 2'd3
  } cmd_e;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StMul  = 6'b000010,
    StComb = 6'b000100,
    StChk  = 6'b001000,
    StRed  = 6'b010000,
    StDone = 6'b100000
  } state_e;

  typedef enum logic [4:0] {
    RdIdle  = 5'b00001,
    RdTwos  = 5'b00010,
    RdAEven = 5'b00100,
    RdLoop  = 5'b01000,
    RdDiv   = 5'b10000
  } red_state_e;

endpackage
`default_nettype wire

>>> hw/rtl/rau_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rau_mul: radix-2 shift-add multiplier
// Unsigned magnitudes, one multiplier bit per cycle.
// -----------------------------------------------------------------------------
module rau_mul (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start_i,
  input  wire logic [rau_pkg::OperandWidth-1:0]   a_i,
  input  wire logic [rau_pkg::OperandWidth-1:0]   b_i,
  output logic                                    done_o,
  output logic [rau_pkg::ProdWidth-1:0]           prod_o
);

  localparam int unsigned OW = rau_pkg::OperandWidth;

  logic [rau_pkg::ProdWidth-1:0]   p_q, p_d;
  logic [OW-1:0]                   mcand_q, mcand_d;
  logic [rau_pkg::MulCntWidth-1:0] cnt_q, cnt_d;
  logic                            run_q, run_d;
  logic                            done_q, done_d;
  logic [OW:0]                     sum;

  always_comb begin
    p_d     = p_q;
    mcand_d = mcand_q;
    cnt_d   = cnt_q;
    run_d   = run_q;
    done_d  = 1'b0;
    // upper half plus multiplicand when the low multiplier bit is set
    sum = {1'b0, p_q[rau_pkg::ProdWidth-1:OW]} + ({(OW + 1){p_q[0]}} & {1'b0, mcand_q});
    if (start_i) begin
      p_d     = {{OW{1'b0}}, b_i};
      mcand_d = a_i;
      cnt_d   = '0;
      run_d   = 1'b1;
    end else if (run_q) begin
      p_d   = {sum, p_q[OW-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == rau_pkg::MulCntWidth'(OW - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q     <= p_d;
    mcand_q <= mcand_d;
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule
`default_nettype wire

>>> hw/rtl/rau_reduce.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// rau_reduce: gcd reduction of a numerator / denominator pair
// Binary gcd one step per cycle, then two restoring dividers, one bit per cycle.
// -----------------------------------------------------------------------------
module rau_reduce (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire rau_pkg::mag_t num_i,
  input  wire rau_pkg::mag_t den_i,   // nonzero
  output logic               done_o,
  output rau_pkg::mag_t      quo_num_o,
  output rau_pkg::mag_t      quo_den_o
);

  localparam int unsigned MW = rau_pkg::MagWidth;

  rau_pkg::red_state_e state_q, state_d;
  rau_pkg::mag_t a_q, a_d, b_q, b_d;
  rau_pkg::mag_t xn_q, xn_d, xd_q, xd_d;
  rau_pkg::mag_t rn_q, rn_d, rd_q, rd_d;
  logic [rau_pkg::DivCntWidth-1:0] cnt_q, cnt_d;
  logic done_q, done_d;

  logic [MW:0] ba_diff, ab_diff;
  logic [MW:0] tn, td, sn, sd;

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    xn_d    = xn_q;
    xd_d    = xd_q;
    rn_d    = rn_q;
    rd_d    = rd_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;

    ba_diff = {1'b0, b_q} - {1'b0, a_q};
    ab_diff = {1'b0, a_q} - {1'b0, b_q};
    // restoring division steps, both dividends share the odd gcd part
    tn = {rn_q, xn_q[MW-1]};
    td = {rd_q, xd_q[MW-1]};
    sn = tn - {1'b0, a_q};
    sd = td - {1'b0, a_q};

    unique case (state_q)
      rau_pkg::RdIdle: begin
        if (start_i) begin
          rn_d  = '0;
          rd_d  = '0;
          cnt_d = '0;
          if (num_i == '0) begin
            // zero numerator: result 0 / 1
            a_d     = rau_pkg::mag_t'(1);
            xn_d    = '0;
            xd_d    = rau_pkg::mag_t'(1);
            state_d = rau_pkg::RdDiv;
          end else begin
            a_d     = num_i;
            b_d     = den_i;
            xn_d    = num_i;
            xd_d    = den_i;
            state_d = rau_pkg::RdTwos;
          end
        end
      end
      rau_pkg::RdTwos: begin
        // common factors of two leave the dividends here
        if (a_q[0] | b_q[0]) begin
          state_d = rau_pkg::RdAEven;
        end else begin
          a_d  = a_q >> 1;
          b_d  = b_q >> 1;
          xn_d = xn_q >> 1;
          xd_d = xd_q >> 1;
        end
      end
      rau_pkg::RdAEven: begin
        if (a_q[0]) begin
          state_d = rau_pkg::RdLoop;
        end else begin
          a_d = a_q >> 1;
        end
      end
      rau_pkg::RdLoop: begin
        if (b_q == '0) begin
          state_d = rau_pkg::RdDiv;
        end else if (!b_q[0]) begin
          b_d = b_q >> 1;
        end else if (ba_diff[MW]) begin
          // a > b: swap, then subtract
          a_d = b_q;
          b_d = ab_diff[MW-1:0];
        end else begin
          b_d = ba_diff[MW-1:0];
        end
      end
      rau_pkg::RdDiv: begin
        cnt_d = cnt_q + 1'b1;
        if (!sn[MW]) begin
          rn_d = sn[MW-1:0];
        end else begin
          rn_d = tn[MW-1:0];
        end
        if (!sd[MW]) begin
          rd_d = sd[MW-1:0];
        end else begin
          rd_d = td[MW-1:0];
        end
        xn_d = {xn_q[MW-2:0], ~sn[MW]};
        xd_d = {xd_q[MW-2:0], ~sd[MW]};
        if (cnt_q == rau_pkg::DivCntWidth'(MW - 1)) begin
          done_d  = 1'b1;
          state_d = rau_pkg::RdIdle;
        end
      end
      default: begin
        state_d = rau_pkg::RdIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rau_pkg::RdIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    b_q  <= b_d;
    xn_q <= xn_d;
    xd_q <= xd_d;
    rn_q <= rn_d;
    rd_q <= rd_d;
  end

  assign done_o    = done_q;
  assign quo_num_o = xn_q;
  assign quo_den_o = xd_q;

endmodule
`default_nettype wire

>>> hw/rtl/rational_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Flow: an item passes the three multipliers, the combine and the zero check, then the gcd
//   reduction and the output register; a zero denominator skips the reduction, and the
//   binary gcd loop makes the time vary with the operands.
// Throughput: one item at a time; the next item is taken once the result reaches the
//   output register, which may still be waiting on m_axis_tready_i.
// Reset: rst_ni asynchronous, active low; clears the sequencers, step counters and valid/done flags only.
// -----------------------------------------------------------------------------
// rational_arithmetic_unit: add, subtract, multiply or divide two fractions
// Serial cross products, sign-magnitude combine, then gcd reduction.
// -----------------------------------------------------------------------------
module rational_arithmetic_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input item
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // num_a [15:0], den_a [31:16], num_b [47:32], den_b [63:48]
  input  wire logic [rau_pkg::InDataWidth-1:0]   s_axis_tdata_i,
  // command [1:0]
  input  wire logic [rau_pkg::CmdWidth-1:0]      s_axis_tuser_i,
  // result item
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // res_num [32:0], res_den [65:33], zero pad above
  output logic [rau_pkg::OutDataWidth-1:0]       m_axis_tdata_o,
  // status [0]: 1 = zero denominator
  output logic [0:0]                             m_axis_tuser_o
);

  localparam int unsigned OW = rau_pkg::OperandWidth;
  localparam int unsigned MW = rau_pkg::MagWidth;
  localparam int unsigned RW = rau_pkg::ResWidth;
  localparam int unsigned EW = rau_pkg::ExtWidth;

  // ---------------------------------------------------------------------------
  // Sequencer state and item registers
  // ---------------------------------------------------------------------------
  rau_pkg::state_e state_q, state_d;
  rau_pkg::cmd_e   cmd_q, cmd_d;
  logic            s1_q, s1_d, s2_q, s2_d, s3_q, s3_d;   // product sign before zero check
  logic            tn_q, tn_d, dn_q, dn_d;               // result signs
  rau_pkg::mag_t   tm_q, tm_d, dm_q, dm_d;               // raw magnitudes
  logic            err_q, err_d;

  logic                    out_vld_q, out_vld_d;
  logic [RW-1:0]           out_num_q, out_num_d, out_den_q, out_den_d;
  logic                    out_st_q, out_st_d;

  // ---------------------------------------------------------------------------
  // Operand split: sign and magnitude of each input field
  // ---------------------------------------------------------------------------
  logic [OW-1:0] f_na, f_da, f_nb, f_db;
  logic [OW-1:0] m_na, m_da, m_nb, m_db;
  logic          sg_na, sg_da, sg_nb, sg_db;
  rau_pkg::cmd_e in_cmd;
  logic          in_acc;

  assign f_na = s_axis_tdata_i[OW-1:0];
  assign f_da = s_axis_tdata_i[2*OW-1:OW];
  assign f_nb = s_axis_tdata_i[3*OW-1:2*OW];
  assign f_db = s_axis_tdata_i[4*OW-1:3*OW];

  assign sg_na = f_na[OW-1];
  assign sg_da = f_da[OW-1];
  assign sg_nb = f_nb[OW-1];
  assign sg_db = f_db[OW-1];

  // most negative value maps to 2^(OW-1), which still fits unsigned
  assign m_na = sg_na ? (~f_na + 1'b1) : f_na;
  assign m_da = sg_da ? (~f_da + 1'b1) : f_da;
  assign m_nb = sg_nb ? (~f_nb + 1'b1) : f_nb;
  assign m_db = sg_db ? (~f_db + 1'b1) : f_db;

  assign in_cmd = rau_pkg::cmd_e'(s_axis_tuser_i);
  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------------------------------------------------------------------
  // Three serial multipliers run together:
  //   p1 = num_a * (den_b, or num_b for multiply)
  //   p2 = den_a * num_b
  //   p3 = den_a * den_b
  // ---------------------------------------------------------------------------
  logic [OW-1:0]                 p1_b;
  logic [rau_pkg::ProdWidth-1:0] p1, p2, p3;
  logic                          d1, d2, d3;

  assign p1_b = (in_cmd == rau_pkg::CmdMul) ? m_nb : m_db;

  rau_mul u_mul_p1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .a_i     (m_na),
    .b_i     (p1_b),
    .done_o  (d1),
    .prod_o  (p1)
  );

  rau_mul u_mul_p2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .a_i     (m_da),
    .b_i     (m_nb),
    .done_o  (d2),
    .prod_o  (p2)
  );

  rau_mul u_mul_p3 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .a_i     (m_da),
    .b_i     (m_db),
    .done_o  (d3),
    .prod_o  (p3)
  );

  // ---------------------------------------------------------------------------
  // Reduction by gcd of the magnitudes
  // ---------------------------------------------------------------------------
  logic          red_start, red_done;
  rau_pkg::mag_t quo_num, quo_den;

  rau_reduce u_reduce (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (red_start),
    .num_i     (tm_q),
    .den_i     (dm_q),
    .done_o    (red_done),
    .quo_num_o (quo_num),
    .quo_den_o (quo_den)
  );

  // ---------------------------------------------------------------------------
  // Combine: signed add/subtract of p1 and p2 in sign-magnitude form
  // ---------------------------------------------------------------------------
  rau_pkg::mag_t e1, e2, e3, sm_sum, sm_d21, sm_m;
  logic [MW:0]   sm_d12;
  logic          n1, n2, n2r, n3, sm_n;

  always_comb begin
    e1  = {1'b0, p1};
    e2  = {1'b0, p2};
    e3  = {1'b0, p3};
    n1  = s1_q & (|p1);
    n2r = s2_q & (|p2);
    n2  = (s2_q ^ (cmd_q == rau_pkg::CmdSub)) & (|p2);
    n3  = s3_q & (|p3);

    sm_sum = e1 + e2;
    sm_d12 = {1'b0, e1} - {1'b0, e2};
    sm_d21 = e2 - e1;
    if (n1 == n2) begin
      sm_m = sm_sum;
      sm_n = n1;
    end else if (!sm_d12[MW]) begin
      sm_m = sm_d12[MW-1:0];
      sm_n = n1;
    end else begin
      sm_m = sm_d21;
      sm_n = n2;
    end
    // zero magnitude is positive
    sm_n = sm_n & (|sm_m);
  end

  // ---------------------------------------------------------------------------
  // Output conversion: sign applied to the reduced magnitudes
  // ---------------------------------------------------------------------------
  logic [EW-1:0] ext_num, ext_den;

  always_comb begin
    ext_num = EW'(quo_num);
    ext_den = EW'(quo_den);
    if (tn_q) begin
      ext_num = ~ext_num + 1'b1;
    end
    if (dn_q) begin
      ext_den = ~ext_den + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    s1_d      = s1_q;
    s2_d      = s2_q;
    s3_d      = s3_q;
    tn_d      = tn_q;
    dn_d      = dn_q;
    tm_d      = tm_q;
    dm_d      = dm_q;
    err_d     = err_q;
    out_vld_d = out_vld_q;
    out_num_d = out_num_q;
    out_den_d = out_den_q;
    out_st_d  = out_st_q;
    red_start = 1'b0;

    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      rau_pkg::StIdle: begin
        if (in_acc) begin
          cmd_d   = in_cmd;
          s1_d    = sg_na ^ ((in_cmd == rau_pkg::CmdMul) ? sg_nb : sg_db);
          s2_d    = sg_da ^ sg_nb;
          s3_d    = sg_da ^ sg_db;
          state_d = rau_pkg::StMul;
        end
      end
      rau_pkg::StMul: begin
        if (d1 && d2 && d3) begin
          state_d = rau_pkg::StComb;
        end
      end
      rau_pkg::StComb: begin
        unique case (cmd_q) inside
          rau_pkg::CmdAdd, rau_pkg::CmdSub: begin
            tm_d = sm_m;
            tn_d = sm_n;
            dm_d = e3;
            dn_d = n3;
          end
          rau_pkg::CmdMul: begin
            tm_d = e1;
            tn_d = n1;
            dm_d = e3;
            dn_d = n3;
          end
          rau_pkg::CmdDiv: begin
            tm_d = e1;
            tn_d = n1;
            dm_d = e2;
            dn_d = n2r;
          end
          default: begin
            tm_d = e1;
            tn_d = n1;
            dm_d = e3;
            dn_d = n3;
          end
        endcase
        state_d = rau_pkg::StChk;
      end
      rau_pkg::StChk: begin
        if (dm_q == '0) begin
          err_d   = 1'b1;
          state_d = rau_pkg::StDone;
        end else begin
          err_d     = 1'b0;
          red_start = 1'b1;
          state_d   = rau_pkg::StRed;
        end
      end
      rau_pkg::StRed: begin
        if (red_done) begin
          state_d = rau_pkg::StDone;
        end
      end
      rau_pkg::StDone: begin
        // result moves to the output register once it is free
        if (!out_vld_q || m_axis_tready_i) begin
          out_vld_d = 1'b1;
          out_st_d  = err_q;
          if (err_q) begin
            out_num_d = '0;
            out_den_d = '0;
          end else begin
            out_num_d = ext_num[RW-1:0];
            out_den_d = ext_den[RW-1:0];
          end
          state_d = rau_pkg::StIdle;
        end
      end
      default: begin
        state_d = rau_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rau_pkg::StIdle;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    s1_q      <= s1_d;
    s2_q      <= s2_d;
    s3_q      <= s3_d;
    tn_q      <= tn_d;
    dn_q      <= dn_d;
    tm_q      <= tm_d;
    dm_q      <= dm_d;
    err_q     <= err_d;
    out_num_q <= out_num_d;
    out_den_q <= out_den_d;
    out_st_q  <= out_st_d;
  end

  assign s_axis_tready_o = (state_q == rau_pkg::StIdle);
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = rau_pkg::OutDataWidth'({out_den_q, out_num_q});
  assign m_axis_tuser_o  = out_st_q;

endmodule
`default_nettype wire

>>> tb/rational_arithmetic_unit_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// rational_arithmetic_unit_tb: self-checking bench for the fraction unit
// Drives fraction pairs and commands into the stream input and predicts each
// reduced fraction from exact wide arithmetic. Every result item is checked
// against the oldest prediction, with random idling on both stream sides.
// -----------------------------------------------------------------------------
module rational_arithmetic_unit_tb;

  // no handshake on either side for this many cycles ends the run
  localparam int unsigned StallLimit = 5000;
  // drain time after the last result, well above the worst gcd latency
  localparam int unsigned DrainCycles = 300;

  typedef struct packed {
    logic [rau_pkg::ResWidth-1:0] num;
    logic [rau_pkg::ResWidth-1:0] den;
    logic                         zero_den;
  } fraction_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              s_axis_tvalid_i;
  logic                              s_axis_tready_o;
  logic [rau_pkg::InDataWidth-1:0]   s_axis_tdata_i;
  logic [rau_pkg::CmdWidth-1:0]      s_axis_tuser_i;
  logic                              m_axis_tvalid_o;
  logic                              m_axis_tready_i = 1'b0;
  logic [rau_pkg::OutDataWidth-1:0]  m_axis_tdata_o;
  logic [0:0]                        m_axis_tuser_o;

  fraction_t   pending_fractions[$];
  int unsigned items_in      = 0;
  int unsigned results_out   = 0;
  int unsigned err_count     = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned ready_hold    = 0;
  bit          idle_en       = 1'b1;

  rational_arithmetic_unit u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic longint unsigned gcd_mag(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Exact products fit easily in 64 bits for 16-bit operands, so the raw
  // terms are plain signed values; the gcd divides them exactly, which keeps
  // the sign where the cross multiplication put it. Zero stays positive.
  function automatic fraction_t reduce_fraction(rau_pkg::cmd_e op,
                                                logic signed [15:0] na,
                                                logic signed [15:0] da,
                                                logic signed [15:0] nb,
                                                logic signed [15:0] db);
    longint    raw_num;
    longint    raw_den;
    longint    g;
    longint    rn;
    longint    rd;
    fraction_t f;
    case (op)
      rau_pkg::CmdAdd: begin
        raw_num = longint'(na) * longint'(db) + longint'(da) * longint'(nb);
        raw_den = longint'(da) * longint'(db);
      end
      rau_pkg::CmdSub: begin
        raw_num = longint'(na) * longint'(db) - longint'(da) * longint'(nb);
        raw_den = longint'(da) * longint'(db);
      end
      rau_pkg::CmdMul: begin
        raw_num = longint'(na) * longint'(nb);
        raw_den = longint'(da) * longint'(db);
      end
      default: begin
        raw_num = longint'(na) * longint'(db);
        raw_den = longint'(da) * longint'(nb);
      end
    endcase
    if (raw_den == 0) begin
      f.num      = '0;
      f.den      = '0;
      f.zero_den = 1'b1;
    end else begin
      g  = longint'(gcd_mag((raw_num < 0) ? -raw_num : raw_num,
                            (raw_den < 0) ? -raw_den : raw_den));
      rn = raw_num / g;
      rd = raw_den / g;
      f.num      = rn[rau_pkg::ResWidth-1:0];
      f.den      = rd[rau_pkg::ResWidth-1:0];
      f.zero_den = 1'b0;
    end
    return f;
  endfunction

  task automatic report_mismatch(string field, logic [rau_pkg::ResWidth-1:0] got,
                                 logic [rau_pkg::ResWidth-1:0] want);
    $display("MISMATCH result %0d %s: got 0x%0h want 0x%0h",
             results_out, field, got, want);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge, predict on input
  // items, check output items against the oldest prediction, and run the
  // watchdog on cycles without any handshake.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    fraction_t want;
    fraction_t got;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        pending_fractions.push_back(reduce_fraction(rau_pkg::cmd_e'(s_axis_tuser_i),
                                                    s_axis_tdata_i[15:0],
                                                    s_axis_tdata_i[31:16],
                                                    s_axis_tdata_i[47:32],
                                                    s_axis_tdata_i[63:48]));
        items_in++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got.num      = m_axis_tdata_o[32:0];
        got.den      = m_axis_tdata_o[65:33];
        got.zero_den = m_axis_tuser_o[0];
        if (pending_fractions.size() == 0) begin
          report_mismatch("unexpected item", got.num, '0);
        end else begin
          want = pending_fractions.pop_front();
          if (got.num !== want.num) report_mismatch("res_num", got.num, want.num);
          if (got.den !== want.den) report_mismatch("res_den", got.den, want.den);
          if (got.zero_den !== want.zero_den)
            report_mismatch("status", rau_pkg::ResWidth'(got.zero_den),
                            rau_pkg::ResWidth'(want.zero_den));
        end
        results_out++;
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog: no handshake for %0d cycles", StallLimit);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Result side back-pressure: random stall bursts while idling is on.
  always @(negedge clk_i) begin
    if (ready_hold == 0) begin
      if (idle_en && $urandom_range(0, 2) == 0) begin
        m_axis_tready_i <= 1'b0;
        ready_hold      = $urandom_range(1, 15);
      end else begin
        m_axis_tready_i <= 1'b1;
        ready_hold      = $urandom_range(1, 40);
      end
    end else if (!idle_en) begin
      // closing stretch: drop any stall burst still in progress
      m_axis_tready_i <= 1'b1;
      ready_hold      = 0;
    end else begin
      ready_hold--;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // One item; valid stays high across back-to-back items, so it is only
  // lowered when a gap is inserted.
  task automatic send_item(rau_pkg::cmd_e op, logic [15:0] na, logic [15:0] da,
                           logic [15:0] nb, logic [15:0] db);
    int unsigned target;
    target = items_in + 1;
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {db, nb, da, na};
    wait (items_in == target);
  endtask

  // Operand mix: full random words, small values (zeros often), extremes,
  // and values with large shared factors so the reduction has work to do.
  function automatic logic [15:0] rand_operand();
    logic [15:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = 16'($urandom());
      4, 5:       v = 16'($signed($urandom_range(0, 16)) - 8);
      6: begin
        case ($urandom_range(0, 4))
          0:       v = 16'h8000;
          1:       v = 16'h7fff;
          2:       v = 16'hffff;
          3:       v = 16'h0000;
          default: v = 16'h0001;
        endcase
      end
      default: begin
        v = 16'($urandom_range(1, 255) << $urandom_range(0, 7));
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  task automatic test_operand_extremes();
    rau_pkg::cmd_e op;
    for (int i = 0; i < 4; i++) begin
      op = rau_pkg::cmd_e'(i);
      send_item(op, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_item(op, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
      send_item(op, 16'hffff, 16'h7fff, 16'h0001, 16'hffff);
    end
  endtask

  task automatic test_special_cases();
    // zero denominators, one per command
    send_item(rau_pkg::CmdAdd, 16'd3, 16'd0, 16'd5, 16'd7);
    send_item(rau_pkg::CmdSub, 16'd3, 16'd4, 16'd5, 16'd0);
    send_item(rau_pkg::CmdMul, 16'd0, 16'd0, 16'd0, 16'd0);
    send_item(rau_pkg::CmdDiv, 16'd3, 16'd4, 16'd0, 16'd7);
    // zero numerator: result is 0 over plus or minus one
    send_item(rau_pkg::CmdMul, 16'd0, 16'd6, 16'd9, 16'hfffd);
    send_item(rau_pkg::CmdSub, 16'd5, 16'd7, 16'd5, 16'd7);
    // negative denominator kept as computed
    send_item(rau_pkg::CmdAdd, 16'd1, 16'hfffe, 16'd1, 16'd4);
    send_item(rau_pkg::CmdDiv, 16'd6, 16'd4, 16'hfff7, 16'd2);
    // already reduced and fully reducible
    send_item(rau_pkg::CmdMul, 16'd7, 16'd11, 16'd13, 16'd17);
    send_item(rau_pkg::CmdAdd, 16'd4096, 16'd8192, 16'd1024, 16'd2048);
  endtask

  task automatic test_random_items(int unsigned count);
    for (int unsigned i = 0; i < count; i++)
      send_item(rau_pkg::cmd_e'($urandom_range(0, 3)), rand_operand(), rand_operand(),
                rand_operand(), rand_operand());
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = rau_pkg::CmdAdd;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_operand_extremes();
    test_special_cases();
    test_random_items(1500);
    // closing stretch with both sides running flat out
    idle_en = 1'b0;
    test_random_items(380);

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (results_out < items_in) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (err_count == 0 && pending_fractions.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
